// File: rtl/core/gbn_pkg.sv
// Shared types, codes and helpers of the Go-Back-N sender.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package gbn_pkg;

   localparam int WINDOW_MAX_DEF   = 8;
   localparam int BUFFER_DEPTH_DEF = 1024;
   localparam int SEQ_BITS_DEF     = 16;
   localparam int QUEUE_DEPTH      = 2;
   localparam int PAYLOAD_BITS     = 160;
   localparam int PAYLOAD_BYTES    = 20;
   localparam int CKS_BITS         = 19;
   localparam int CSR_ADDR_BITS    = 3;

   // request codes on the input channel
   localparam logic [1:0] REQ_MSG  = 2'd0;
   localparam logic [1:0] REQ_ACK  = 2'd1;
   localparam logic [1:0] REQ_TMO  = 2'd2;
   localparam logic [1:0] REQ_RSVD = 2'd3;

   localparam logic CSR_IDX_WINDOW = 1'b0;

   typedef enum logic [1:0] {
      EV_MSG,
      EV_ACK,
      EV_TMO,
      EV_NONE
   } ev_type;

   typedef enum logic [1:0] {
      TMR_LEAVE = 2'd0,
      TMR_START = 2'd1,
      TMR_STOP  = 2'd2
   } tmr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEND,
      ST_RESEND
   } state_type;

   typedef struct packed {
      ev_type                    ev;
      logic [PAYLOAD_BITS-1:0]   payload;
      logic [15:0]               ack;
      logic                      cks_ok;
   } cmd_type;

   // sum of the 20 payload bytes, each taken as signed
   function automatic logic signed [12:0] byte_sum(input logic [PAYLOAD_BITS-1:0] p);
      logic signed [12:0] s;
      s = '0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         s = s + 13'(signed'(p[8*i +: 8]));
      end
      return s;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/gbn_front.sv
// Front end: registers an accepted event, verifies an ACK checksum, issues a command.
// Depends on gbn_pkg.
`default_nettype none
module gbn_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_type,
   input  wire logic [gbn_pkg::PAYLOAD_BITS-1:0] req_payload,
   input  wire logic [15:0]                   req_pkt_seq,
   input  wire logic [15:0]                   req_pkt_ack,
   input  wire logic signed [31:0]            req_pkt_checksum,
   output logic                               push,
   output gbn_pkg::cmd_type                   push_cmd,
   input  wire logic                          q_full
);
   import gbn_pkg::*;

   logic                        fe_valid_ff, fe_valid_in;
   logic [1:0]                  fe_type_ff;
   logic [PAYLOAD_BITS-1:0]     fe_payload_ff;
   logic [15:0]                 fe_seq_ff, fe_ack_ff;
   logic signed [31:0]          fe_cks_ff;
   logic                        accept;
   logic signed [33:0]          calc;

   assign busy   = fe_valid_ff & q_full;
   assign accept = start & ~busy;
   assign push   = fe_valid_ff & ~q_full;

   always_comb begin
      fe_valid_in = fe_valid_ff;
      if (accept) begin
         fe_valid_in = 1'b1;
      end else if (push) begin
         fe_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fe_valid_ff <= 1'b0;
      end else begin
         fe_valid_ff <= fe_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fe_type_ff    <= req_type;
         fe_payload_ff <= req_payload;
         fe_seq_ff     <= req_pkt_seq;
         fe_ack_ff     <= req_pkt_ack;
         fe_cks_ff     <= req_pkt_checksum;
      end
   end

   // classify and check the carried checksum
   always_comb begin
      calc = 34'(byte_sum(fe_payload_ff)) + signed'({18'b0, fe_seq_ff})
           + signed'({18'b0, fe_ack_ff});
      push_cmd.payload = fe_payload_ff;
      push_cmd.ack     = fe_ack_ff;
      push_cmd.cks_ok  = (calc == 34'(fe_cks_ff));
      unique case (fe_type_ff)
         REQ_MSG: push_cmd.ev = EV_MSG;
         REQ_ACK: push_cmd.ev = EV_ACK;
         REQ_TMO: push_cmd.ev = EV_TMO;
         default: push_cmd.ev = EV_NONE;
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/core/gbn_queue.sv
// Short command queue between front and back end.
// Depends on gbn_pkg.
`default_nettype none
module gbn_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire gbn_pkg::cmd_type  push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output gbn_pkg::cmd_type       pop_cmd,
   output logic                   empty
);
   import gbn_pkg::*;

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         q_mem [QUEUE_DEPTH];
   logic [IW-1:0]   rd_ff, rd_in, wr_ff, wr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign full    = (cnt_ff == CW'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign pop_cmd = q_mem[rd_ff];

   always_comb begin
      rd_in  = rd_ff;
      wr_in  = wr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == IW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == IW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/gbn_back.sv
// Back end: message buffer, send window and the sequencer that emits results.
// Depends on gbn_pkg.
`default_nettype none
module gbn_back #(
   parameter int WINDOW_MAX   = gbn_pkg::WINDOW_MAX_DEF,
   parameter int BUFFER_DEPTH = gbn_pkg::BUFFER_DEPTH_DEF,
   parameter int SEQ_BITS     = gbn_pkg::SEQ_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [3:0]                    window_size,
   input  wire logic                          q_empty,
   input  wire gbn_pkg::cmd_type              q_cmd,
   output logic                               pop,
   output logic                               rsp_valid,
   output logic                               rsp_packet_valid,
   output logic [15:0]                        rsp_seq_num,
   output logic [gbn_pkg::PAYLOAD_BITS-1:0]   rsp_payload,
   output logic signed [gbn_pkg::CKS_BITS-1:0] rsp_out_checksum,
   output logic [1:0]                         rsp_timer_cmd,
   output logic                               rsp_last
);
   import gbn_pkg::*;

   localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int KW = $clog2(WINDOW_MAX + 1);
   localparam int HW = $clog2(BUFFER_DEPTH);
   localparam int FW = $clog2(BUFFER_DEPTH + 1);
   localparam logic [SEQ_BITS-1:0] SEQ_MASK = '1;

   state_type               state_ff, state_in;
   ev_type                  ev_ff, ev_in;
   logic                    bz_ff, bz_in;
   logic [KW-1:0]           k_ff, k_in;
   logic [SEQ_BITS-1:0]     base_ff, base_in, next_ff, next_in;
   logic [SW-1:0]           bslot_ff, bslot_in, nslot_ff, nslot_in, rslot_ff, rslot_in;
   logic [HW-1:0]           head_ff, head_in, tail_ff, tail_in;
   logic [FW-1:0]           count_ff, count_in;
   logic [PAYLOAD_BITS-1:0] rd_data_ff;
   logic [PAYLOAD_BITS-1:0] fifo_mem [BUFFER_DEPTH];
   logic [PAYLOAD_BITS-1:0] win_mem  [WINDOW_MAX];
   logic                    fifo_we, win_we;

   logic                    rv_ff, rv_in, pv_ff, pv_in, last_ff, last_in;
   logic [15:0]             seq_o_ff, seq_o_in;
   logic [PAYLOAD_BITS-1:0] pl_ff, pl_in;
   logic signed [CKS_BITS-1:0] cks_ff, cks_in;
   logic [1:0]              tc_ff, tc_in;

   logic [SEQ_BITS-1:0]     outst, a, d;
   logic [KW-1:0]           win;
   logic [SW:0]             s0;
   logic [SW-1:0]           a_slot;
   logic                    more;

   function automatic logic [SW-1:0] inc_slot(input logic [SW-1:0] slot,
                                              input logic [SEQ_BITS-1:0] seq);
      logic [SW-1:0] r;
      r = (slot == SW'(WINDOW_MAX - 1)) ? '0 : slot + 1'b1;
      if (seq == SEQ_MASK) begin
         r = '0;
      end
      return r;
   endfunction

   assign outst = next_ff - base_ff;
   assign win   = (window_size == 4'd0) ? KW'(1)
                : (33'(window_size) > 33'(WINDOW_MAX)) ? KW'(WINDOW_MAX) : KW'(window_size);
   assign a     = SEQ_BITS'(q_cmd.ack);
   assign d     = a - base_ff;
   assign pop   = (state_ff == ST_IDLE) & ~q_empty;

   always_comb begin
      state_in = state_ff;
      ev_in    = ev_ff;
      bz_in    = bz_ff;
      k_in     = k_ff;
      base_in  = base_ff;
      next_in  = next_ff;
      bslot_in = bslot_ff;
      nslot_in = nslot_ff;
      rslot_in = rslot_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      fifo_we  = 1'b0;
      win_we   = 1'b0;
      rv_in    = 1'b0;
      pv_in    = 1'b0;
      last_in  = 1'b0;
      seq_o_in = '0;
      pl_in    = '0;
      cks_in   = '0;
      tc_in    = TMR_LEAVE;
      more     = 1'b0;
      s0       = (SW + 1)'(bslot_ff) + (SW + 1)'(d);
      if (s0 >= (SW + 1)'(WINDOW_MAX)) begin
         s0 = s0 - (SW + 1)'(WINDOW_MAX);
      end
      a_slot = (a >= base_ff) ? SW'(s0) : SW'(a);
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               ev_in = q_cmd.ev;
               k_in  = '0;
               unique case (q_cmd.ev)
                  EV_MSG: begin
                     bz_in = (outst == '0);
                     if (count_ff != FW'(BUFFER_DEPTH)) begin
                        fifo_we  = 1'b1;
                        tail_in  = (tail_ff == HW'(BUFFER_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                     state_in = ST_CHECK;
                  end
                  EV_ACK: begin
                     if (q_cmd.cks_ok && d < outst) begin
                        base_in  = a + 1'b1;
                        bslot_in = inc_slot(a_slot, a);
                        state_in = ST_CHECK;
                     end else begin
                        rv_in   = 1'b1;
                        last_in = 1'b1;
                     end
                  end
                  EV_TMO: begin
                     if (outst != '0) begin
                        rslot_in = bslot_ff;
                        state_in = ST_RESEND;
                     end else begin
                        rv_in   = 1'b1;
                        last_in = 1'b1;
                     end
                  end
                  default: begin
                     rv_in   = 1'b1;
                     last_in = 1'b1;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            // reached before every send; wait for the registered read of the oldest message
            if (count_ff != '0 && 33'(outst) < 33'(win)) begin
               state_in = ST_SEND;
            end else begin
               rv_in    = 1'b1;
               last_in  = 1'b1;
               if (ev_ff == EV_ACK) begin
                  tc_in = (outst == '0) ? TMR_STOP : TMR_START;
               end
               state_in = ST_IDLE;
            end
         end
         ST_SEND: begin
            win_we   = 1'b1;
            head_in  = (head_ff == HW'(BUFFER_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
            next_in  = next_ff + 1'b1;
            nslot_in = inc_slot(nslot_ff, next_ff);
            k_in     = k_ff + 1'b1;
            rv_in    = 1'b1;
            pv_in    = 1'b1;
            seq_o_in = 16'(next_ff);
            pl_in    = rd_data_ff;
            cks_in   = CKS_BITS'(byte_sum(rd_data_ff)) + CKS_BITS'({next_ff, 1'b0});
            more     = (count_ff > FW'(1)) && (33'(outst) + 33'd1 < 33'(win))
                     && (33'(k_ff) + 33'd1 < 33'(WINDOW_MAX));
            if (more) begin
               state_in = ST_CHECK;
            end else begin
               last_in  = 1'b1;
               tc_in    = (ev_ff == EV_ACK || bz_ff) ? TMR_START : TMR_LEAVE;
               state_in = ST_IDLE;
            end
         end
         ST_RESEND: begin
            rv_in    = 1'b1;
            pv_in    = 1'b1;
            seq_o_in = 16'(base_ff + SEQ_BITS'(k_ff));
            pl_in    = win_mem[rslot_ff];
            cks_in   = CKS_BITS'(byte_sum(win_mem[rslot_ff]))
                     + CKS_BITS'({base_ff + SEQ_BITS'(k_ff), 1'b0});
            rslot_in = inc_slot(rslot_ff, base_ff + SEQ_BITS'(k_ff));
            k_in     = k_ff + 1'b1;
            if (33'(k_ff) + 33'd1 == 33'(outst)) begin
               last_in  = 1'b1;
               tc_in    = TMR_START;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ev_ff    <= EV_NONE;
         bz_ff    <= 1'b0;
         k_ff     <= '0;
         base_ff  <= '0;
         next_ff  <= '0;
         bslot_ff <= '0;
         nslot_ff <= '0;
         rslot_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ev_ff    <= ev_in;
         bz_ff    <= bz_in;
         k_ff     <= k_in;
         base_ff  <= base_in;
         next_ff  <= next_in;
         bslot_ff <= bslot_in;
         nslot_ff <= nslot_in;
         rslot_ff <= rslot_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      pv_ff    <= pv_in;
      last_ff  <= last_in;
      seq_o_ff <= seq_o_in;
      pl_ff    <= pl_in;
      cks_ff   <= cks_in;
      tc_ff    <= tc_in;
   end

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[tail_ff] <= q_cmd.payload;
      end
      rd_data_ff <= fifo_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[nslot_ff] <= rd_data_ff;
      end
   end

   assign rsp_valid        = rv_ff;
   assign rsp_packet_valid = pv_ff;
   assign rsp_seq_num      = seq_o_ff;
   assign rsp_payload      = pl_ff;
   assign rsp_out_checksum = cks_ff;
   assign rsp_timer_cmd    = tc_ff;
   assign rsp_last         = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FW'(BUFFER_DEPTH)) else $error("buffer count above depth");
   a_outst_bound: assert property (@(posedge clock) disable iff (reset)
      33'(outst) <= 33'(WINDOW_MAX)) else $error("too many packets outstanding");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rv_ff && last_ff |-> state_ff == ST_IDLE) else $error("sequencer busy after last");
   a_tmr_last: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !last_ff |-> tc_ff == TMR_LEAVE) else $error("timer command before last");

endmodule
`default_nettype wire

// File: rtl/core/go_back_n_sender.sv
// Top level of the Go-Back-N sender: register port, front end, queue, back end.
// Depends on gbn_pkg, gbn_front, gbn_queue and gbn_back.
`default_nettype none
// An event (message, ACK packet or timer expiry) is a transfer at a clock edge with start
// high and busy low. The front end registers it and checks an ACK's checksum in the next
// cycle, then hands a command to a two-entry queue, so a new event is usually taken while
// the previous one is still being carried out. Each result is marked by rsp_valid high for
// exactly one cycle; the receiver cannot stall it, and rsp_last marks the final
// result of an event, which also carries the timer command. The back end takes an event
// from the queue in its idle state, then sends each packet from the message buffer by way
// of a check state that waits for its registered memory read, then a send state, and
// resends a window's packets one per cycle on a timeout; an event that sends nothing
// yields its single empty result. No clearing pass follows reset.
module go_back_n_sender #(
   parameter int WINDOW_MAX   = gbn_pkg::WINDOW_MAX_DEF,
   parameter int BUFFER_DEPTH = gbn_pkg::BUFFER_DEPTH_DEF,
   parameter int SEQ_BITS     = gbn_pkg::SEQ_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [1:0]                         req_type,
   input  wire logic [63:0]                        req_payload_lo,
   input  wire logic [63:0]                        req_payload_mid,
   input  wire logic [31:0]                        req_payload_hi,
   input  wire logic [15:0]                        req_pkt_seq,
   input  wire logic [15:0]                        req_pkt_ack,
   input  wire logic signed [31:0]                 req_pkt_checksum,
   output logic                                    rsp_valid,
   output logic                                    rsp_packet_valid,
   output logic [15:0]                             rsp_seq_num,
   output logic [63:0]                             rsp_out_payload_lo,
   output logic [63:0]                             rsp_out_payload_mid,
   output logic [31:0]                             rsp_out_payload_hi,
   output logic signed [gbn_pkg::CKS_BITS-1:0]     rsp_out_checksum,
   output logic [1:0]                              rsp_timer_cmd,
   output logic                                    rsp_last,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [gbn_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  wire logic [31:0]                        pwdata,
   output logic [31:0]                             prdata,
   output logic                                    pready
);
   import gbn_pkg::*;

   logic [3:0]              win_size_ff, win_size_in;
   logic                    push, q_full, q_empty, pop;
   cmd_type                 push_cmd, q_cmd;
   logic [PAYLOAD_BITS-1:0] rsp_payload;

   // register port: one register, window_size, at byte address 0
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_IDX_WINDOW) ? {28'b0, win_size_ff} : '0;

   always_comb begin
      win_size_in = win_size_ff;
      // take the write transfer; addresses beyond the register are dropped
      if (psel && penable && pwrite && pready && paddr[2] == CSR_IDX_WINDOW) begin
         win_size_in = pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff <= 4'd8;
      end else begin
         win_size_ff <= win_size_in;
      end
   end

   // front end: hold the event, classify it, check an ACK
   gbn_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_payload      ({req_payload_hi, req_payload_mid, req_payload_lo}),
      .req_pkt_seq      (req_pkt_seq),
      .req_pkt_ack      (req_pkt_ack),
      .req_pkt_checksum (req_pkt_checksum),
      .push             (push),
      .push_cmd         (push_cmd),
      .q_full           (q_full)
   );

   gbn_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .pop_cmd  (q_cmd),
      .empty    (q_empty)
   );

   // back end: buffer messages, keep the window, emit the results of each event
   gbn_back #(
      .WINDOW_MAX   (WINDOW_MAX),
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .SEQ_BITS     (SEQ_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .window_size      (win_size_ff),
      .q_empty          (q_empty),
      .q_cmd            (q_cmd),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_packet_valid (rsp_packet_valid),
      .rsp_seq_num      (rsp_seq_num),
      .rsp_payload      (rsp_payload),
      .rsp_out_checksum (rsp_out_checksum),
      .rsp_timer_cmd    (rsp_timer_cmd),
      .rsp_last         (rsp_last)
   );

   assign rsp_out_payload_lo  = rsp_payload[63:0];
   assign rsp_out_payload_mid = rsp_payload[127:64];
   assign rsp_out_payload_hi  = rsp_payload[159:128];

endmodule
`default_nettype wire
